>>> rtl/lcdenc_pkg.sv
package lcdenc_pkg;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] CMD_LINE0    = 8'h80;
    localparam logic [7:0] CMD_LINE1    = 8'hC0;
    localparam logic [3:0] INIT_NIBBLES = 4'd14;
    localparam logic [3:0] CHAR_NIBBLES = 4'd2;
    localparam logic [1:0] PHASE_LAST   = 2'd2;
    localparam logic [1:0] PHASE_STROBE = 2'd1;

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed
    {
        logic load;
        logic advance;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic out_free;
        logic final_byte;
        logic null_item;
    } dp_status_t;

    // nibble sequence of the power-up init: 3,3,3,2 then 06 0F 14 28 01
    function automatic logic [3:0] init_nibble(input logic [3:0] idx);
        logic [3:0] nib;
        case (idx)
            4'd0:    nib = 4'h3;
            4'd1:    nib = 4'h3;
            4'd2:    nib = 4'h3;
            4'd3:    nib = 4'h2;
            4'd4:    nib = 4'h0;
            4'd5:    nib = 4'h6;
            4'd6:    nib = 4'h0;
            4'd7:    nib = 4'hF;
            4'd8:    nib = 4'h1;
            4'd9:    nib = 4'h4;
            4'd10:   nib = 4'h2;
            4'd11:   nib = 4'h8;
            4'd12:   nib = 4'h0;
            4'd13:   nib = 4'h1;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

endpackage

>>> rtl/char_lcd_expander_byte_encoder.sv
// Encodes characters and init requests into the byte stream for an 8-bit I/O
// expander driving a character LCD in 4-bit mode. Each nibble leaves as three
// bytes (base, base with enable, base), high nibble first, backlight always on,
// register select 1 for characters and 0 for commands. A character or newline
// gives six bytes, an init request 42, a null character (code 0) none; last
// marks the final byte of each item. Bytes are produced one per clock from a
// nibble/phase counter into a single output register, so the rate is set by
// that output stage and holds while the output is not stalled, with the
// next item taken in the same cycle as the previous item's final byte when the
// output is not stalled.
module char_lcd_expander_byte_encoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic [7:0] code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] expander_byte,
    output logic       last
);
    import lcdenc_pkg::*;

    // command and status between sequencer and byte datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: accepts items and paces the byte transfers
    lcdenc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: line bit, nibble/phase counters, output register
    lcdenc_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .code          (code),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .expander_byte (expander_byte),
        .last          (last)
    );

endmodule

>>> rtl/lcdenc_ctrl.sv
module lcdenc_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  lcdenc_pkg::dp_status_t  status,
    output lcdenc_pkg::ctrl_cmd_t   cmd
);
    import lcdenc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   take;
    logic   done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // outputs
    always_comb
    begin
        cmd.advance = 1'b0;
        done        = 1'b0;
        in_stall    = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_RUN:
            begin
                cmd.advance = status.out_free;
                done        = status.out_free && status.final_byte;
                in_stall    = !done;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
        take     = in_valid && !in_stall;
        cmd.load = take && !status.null_item;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cmd.load)
                begin
                    state_next = ST_RUN;
                end
                else if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_RUN)
        else $error("load did not start a sequence");

    a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !cmd.load) |=> state_reg == ST_IDLE)
        else $error("sequence did not end after final byte");

    a_idle_no_advance: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !cmd.advance)
        else $error("byte emitted while idle");

endmodule

>>> rtl/lcdenc_dp.sv
module lcdenc_dp
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    op,
    input  logic [7:0]              code,
    input  lcdenc_pkg::ctrl_cmd_t   cmd,
    output lcdenc_pkg::dp_status_t  status,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [7:0]              expander_byte,
    output logic                    last
);
    import lcdenc_pkg::*;

    logic       line_reg;
    logic       init_reg;
    logic       rs_reg;
    logic [7:0] data_reg;
    logic [3:0] nib_idx_reg;
    logic [1:0] phase_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    logic [3:0] nib_total;
    logic [3:0] cur_nib;
    logic [7:0] cur_byte;
    logic       is_newline;

    assign nib_total  = init_reg ? INIT_NIBBLES : CHAR_NIBBLES;
    assign is_newline = (code == NEWLINE_CODE);

    always_comb
    begin
        if (init_reg)
        begin
            cur_nib = init_nibble(nib_idx_reg);
        end
        else
        begin
            cur_nib = nib_idx_reg[0] ? data_reg[3:0] : data_reg[7:4];
        end
        cur_byte = {cur_nib, 1'b1, (phase_reg == PHASE_STROBE), 1'b0, rs_reg};
    end

    assign status.out_free   = !out_valid_reg || !out_stall;
    assign status.final_byte = (phase_reg == PHASE_LAST) &&
                               (nib_idx_reg == nib_total - 4'd1);
    assign status.null_item  = !op && (code == 8'd0);

    // control state of the sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg      <= 1'b0;
            nib_idx_reg   <= 4'd0;
            phase_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.load)
            begin
                nib_idx_reg <= 4'd0;
                phase_reg   <= 2'd0;
                if (!op && is_newline)
                begin
                    line_reg <= !line_reg;
                end
            end
            else if (cmd.advance)
            begin
                if (status.final_byte)
                begin
                    nib_idx_reg <= 4'd0;
                    phase_reg   <= 2'd0;
                end
                else if (phase_reg == PHASE_LAST)
                begin
                    nib_idx_reg <= nib_idx_reg + 4'd1;
                    phase_reg   <= 2'd0;
                end
                else
                begin
                    phase_reg <= phase_reg + 2'd1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            init_reg <= op;
            if (op)
            begin
                rs_reg   <= 1'b0;
                data_reg <= 8'd0;
            end
            else if (is_newline)
            begin
                rs_reg   <= 1'b0;
                data_reg <= line_reg ? CMD_LINE0 : CMD_LINE1;
            end
            else
            begin
                rs_reg   <= 1'b1;
                data_reg <= code;
            end
        end
        if (cmd.advance)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= status.final_byte;
        end
    end

    assign out_valid     = out_valid_reg;
    assign expander_byte = out_byte_reg;
    assign last          = out_last_reg;

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("nibble phase out of range");

    a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && !cmd.advance) |-> (phase_reg == 2'd0 && nib_idx_reg == 4'd0))
        else $error("new item loaded mid-sequence");

    a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |=> out_valid_reg)
        else $error("emitted byte not held in output register");

endmodule
